/* hw/rtl/smva_pkg.sv */
// Shared constants and types for the sparse matrix-vector accumulate unit.
// Used by the interfaces, the controller, the datapath and the top level.
package smva_pkg;

   localparam int X_DEPTH  = 1024;
   localparam int X_ADDR_W = $clog2(X_DEPTH);
   localparam logic [31:0] X_DEPTH_U32 = 32'(X_DEPTH);

   localparam int OP_W  = 2;
   localparam int IDX_W = 10;
   localparam int DAT_W = 32;
   localparam int ACC_W = 64;

   localparam logic [OP_W-1:0] OP_WRITE_X = 2'd0;
   localparam logic [OP_W-1:0] OP_NONZERO = 2'd1;
   localparam logic [OP_W-1:0] OP_ROW_END = 2'd2;

   localparam logic [DAT_W-1:0] SCALE_RESET = 32'h0001_0000;

   typedef struct packed {
      logic capture;
      logic mem_write;
      logic mem_read;
      logic mul;
      logic acc;
      logic fin_mul;
      logic fin_out;
   } smva_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            last;
      logic            rsp_busy;
   } smva_status_type;

endpackage

/* hw/rtl/smva_req_if.sv */
// Input item channel of the sparse matrix-vector accumulate unit.
// Depends on smva_pkg for field widths.
interface smva_req_if import smva_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         op;
   logic [IDX_W-1:0]        index;
   logic signed [DAT_W-1:0] value;
   logic                    last_in_row;
   logic signed [DAT_W-1:0] y_old;

   modport source (output valid, op, index, value, last_in_row, y_old, input ready);
   modport sink   (input valid, op, index, value, last_in_row, y_old, output ready);
endinterface

/* hw/rtl/smva_rsp_if.sv */
// Result item channel of the sparse matrix-vector accumulate unit.
// Depends on smva_pkg for field widths.
interface smva_rsp_if import smva_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [DAT_W-1:0] y_new;
   logic                    saturated;

   modport source (output valid, y_new, saturated, input ready);
   modport sink   (input valid, y_new, saturated, output ready);
endinterface

/* hw/rtl/smva_ctrl.sv */
// Sequencer for the sparse matrix-vector accumulate unit: one item at a time.
// Depends on smva_pkg; drives the datapath through smva_cmd_type.
module smva_ctrl import smva_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  smva_status_type status,
   output smva_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_ACC    = 3'd3;
   localparam logic [2:0] S_FIN1   = 3'd4;
   localparam logic [2:0] S_FIN2   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.op)
               OP_WRITE_X: begin
                  cmd.mem_write = 1'b1;
                  state_in      = S_IDLE;
               end
               OP_NONZERO: begin
                  cmd.mem_read = 1'b1;
                  state_in     = S_MUL;
               end
               OP_ROW_END: state_in = S_FIN1;
               default:    state_in = S_IDLE;
            endcase
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.last ? S_FIN1 : S_IDLE;
         end
         S_FIN1: begin
            cmd.fin_mul = 1'b1;
            state_in    = S_FIN2;
         end
         S_FIN2: begin
            if (!status.rsp_busy) begin
               cmd.fin_out = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted item did not enter decode");

   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> ($past(state_ff) == S_MUL))
      else $error("accumulate without a product");

   a_fin_in_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN2) |-> ($past(state_ff) == S_FIN1 || $past(state_ff) == S_FIN2))
      else $error("row finish out of order");

   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.fin_out |-> !status.rsp_busy)
      else $error("result written over a waiting item");
`endif

endmodule

/* hw/rtl/smva_dp.sv */
// Datapath of the sparse matrix-vector accumulate unit: x store, multiplier,
// row accumulator, row-end scaling and result register. Depends on smva_pkg.
module smva_dp import smva_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  smva_cmd_type            cmd,
   output smva_status_type         status,
   input  logic                    csr_wr_en,
   input  logic [DAT_W-1:0]        csr_wr_data,
   input  logic [OP_W-1:0]         req_op,
   input  logic [IDX_W-1:0]        req_index,
   input  logic [DAT_W-1:0]        req_value,
   input  logic                    req_last_in_row,
   input  logic [DAT_W-1:0]        req_y_old,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [DAT_W-1:0]        rsp_y_new,
   output logic                    rsp_saturated
);

   logic [DAT_W-1:0] x_mem [X_DEPTH];

   logic [DAT_W-1:0]        scale_ff;
   logic [OP_W-1:0]         op_ff;
   logic [IDX_W-1:0]        index_ff;
   logic signed [DAT_W-1:0] value_ff;
   logic                    last_ff;
   logic signed [DAT_W-1:0] y_old_ff;
   logic [DAT_W-1:0]        x_rd_ff;
   logic                    in_range_ff;
   logic signed [ACC_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] row_sum_ff;
   logic                    row_sat_ff;
   logic signed [ACC_W-1:0] prod_hi_ff;
   logic signed [65:0]      prod_lo_ff;
   logic                    rsp_valid_ff;
   logic [DAT_W-1:0]        y_new_ff;
   logic                    sat_ff;

   logic                    in_range;
   logic [X_ADDR_W-1:0]     x_addr;
   logic signed [DAT_W-1:0] x_val;
   logic [ACC_W:0]          acc_sum;
   logic signed [32:0]      scale_ext;
   logic signed [32:0]      lo_ext;
   logic [65:0]             low_sum;
   logic [65:0]             total;
   logic                    clip_hi;
   logic                    clip_lo;
   logic [DAT_W-1:0]        y_new_in;
   logic                    sat_in;

   assign in_range = ({22'd0, index_ff} < X_DEPTH_U32);
   assign x_addr   = X_ADDR_W'(index_ff);
   assign x_val    = in_range_ff ? $signed(x_rd_ff) : '0;
   assign acc_sum  = {row_sum_ff[ACC_W-1], row_sum_ff} + {prod_ff[ACC_W-1], prod_ff};

   assign scale_ext = {scale_ff[DAT_W-1], scale_ff};
   assign lo_ext    = {1'b0, row_sum_ff[31:0]};

   // round half up, then floor by 2^32
   assign low_sum = prod_lo_ff + 66'sh0_8000_0000;
   assign total   = {{2{prod_hi_ff[63]}}, prod_hi_ff}
                  + {{32{low_sum[65]}}, low_sum[65:32]}
                  + {{34{y_old_ff[31]}}, y_old_ff};
   assign clip_hi = !total[65] && (total[64:31] != '0);
   assign clip_lo = total[65] && (total[64:31] != '1);

   always_comb begin
      if (scale_ff == '0) begin
         y_new_in = y_old_ff;
         sat_in   = 1'b0;
      end else if (clip_hi) begin
         y_new_in = 32'h7FFF_FFFF;
         sat_in   = 1'b1;
      end else if (clip_lo) begin
         y_new_in = 32'h8000_0000;
         sat_in   = 1'b1;
      end else begin
         y_new_in = total[31:0];
         sat_in   = row_sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write && in_range) begin
         x_mem[x_addr] <= value_ff;
      end
      if (cmd.mem_read) begin
         x_rd_ff     <= x_mem[x_addr];
         in_range_ff <= in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         index_ff <= req_index;
         value_ff <= req_value;
         last_ff  <= req_last_in_row;
         y_old_ff <= req_y_old;
      end
      if (cmd.mul) begin
         prod_ff <= value_ff * x_val;
      end
      if (cmd.fin_mul) begin
         prod_hi_ff <= $signed(scale_ff) * $signed(row_sum_ff[63:32]);
         prod_lo_ff <= scale_ext * lo_ext;
      end
      if (cmd.fin_out) begin
         y_new_ff <= y_new_in;
         sat_ff   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_RESET;
         row_sum_ff   <= '0;
         row_sat_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            scale_ff <= csr_wr_data;
         end
         if (cmd.fin_out) begin
            row_sum_ff <= '0;
            row_sat_ff <= 1'b0;
         end else if (cmd.acc) begin
            if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
               row_sum_ff <= acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                            : {1'b0, {(ACC_W-1){1'b1}}};
               row_sat_ff <= 1'b1;
            end else begin
               row_sum_ff <= acc_sum[ACC_W-1:0];
            end
         end
         if (cmd.fin_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.op       = op_ff;
   assign status.last     = last_ff;
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_y_new     = y_new_ff;
   assign rsp_saturated = sat_ff;

endmodule

/* hw/rtl/csr_sparse_matvec_accumulate_unit.sv */
// Sparse matrix-vector accumulate unit, y += a*A*x, compressed-row stream.
// Depends on smva_pkg, smva_req_if, smva_rsp_if, smva_ctrl and smva_dp.
//
// Usage: write x first with op 0 items (index, value), then stream the
// nonzeros row by row with op 1 (column index, value, last_in_row) or mark an
// empty row with op 2. Each row end returns one item on rsp_chan: y_new =
// sat(y_old + a*row_sum) and a saturated flag. csr_wr_en/csr_wr_data set a
// (Q16.16) while the unit is idle.
// Timing: one item in flight; the next item is accepted when the sequencer
// is back in idle. An x write passes decode and the store write; a nonzero
// passes decode with the x store read, multiply and accumulate; a nonzero
// that ends a row and an empty-row marker then go on through the two-step
// row-end scaling (multiply, then round/add/saturate), and rsp_chan.valid
// rises from the result register after the last step.
// Reset: synchronous; req_chan.ready is low while reset is high; clears the
// accumulator, clip flag and result valid and sets a to 1.0. The x store is
// not cleared; read only entries written.
// Stall: the result register holds while rsp_chan.ready is low; new items
// are still taken, and a following row end waits in its last step.
module csr_sparse_matvec_accumulate_unit import smva_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   smva_req_if.sink         req_chan,
   smva_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [DAT_W-1:0] csr_wr_data
);

   smva_cmd_type    cmd;
   smva_status_type status;

   smva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   smva_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_op          (req_chan.op),
      .req_index       (req_chan.index),
      .req_value       (req_chan.value),
      .req_last_in_row (req_chan.last_in_row),
      .req_y_old       (req_chan.y_old),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_y_new       (rsp_chan.y_new),
      .rsp_saturated   (rsp_chan.saturated)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for csr_sparse_matvec_accumulate_unit: x writes, nonzeros and row ends
// with random handshake gaps, checked item by item against a fixed-point predictor.
// Depends on smva_pkg, smva_req_if, smva_rsp_if and the unit itself.
module tb_top;
   import smva_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT   = 1000;
   localparam int HOLD_CYCLES   = 100;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 200;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] index;
      logic [DAT_W-1:0] value;
      logic             last;
      logic [DAT_W-1:0] y_old;
   } stream_item_type;

   typedef struct {
      logic [DAT_W-1:0] y_new;
      logic             saturated;
   } y_result_type;

   // y += a*A*x predictor plus queue of row results still to come
   class spmv_book;
      localparam longint Y_MAX      = 64'sd2147483647;
      localparam longint Y_MIN      = -64'sd2147483648;
      localparam longint ROUND_HALF = 64'sd2147483648;

      logic [DAT_W-1:0]        x_mem [X_DEPTH];
      logic signed [ACC_W-1:0] row_acc;
      logic                    row_clip;
      logic signed [DAT_W-1:0] scale;
      y_result_type            y_due [$];
      int                      mismatches;

      function new();
         row_acc    = '0;
         row_clip   = 1'b0;
         scale      = SCALE_RESET;
         mismatches = 0;
      endfunction

      function void set_scale(logic [DAT_W-1:0] v);
         scale = v;
      endfunction

      function int pending();
         return y_due.size();
      endfunction

      function void close_row(logic signed [DAT_W-1:0] y_old);
         y_result_type r;
         longint       hi;
         longint       lo;
         longint       t;
         r.y_new     = y_old;
         r.saturated = 1'b0;
         if (scale != 0) begin
            hi = longint'($signed(row_acc[63:32]));
            lo = longint'({32'b0, row_acc[31:0]});
            t  = longint'(scale) * hi + ((longint'(scale) * lo + ROUND_HALF) >>> 32)
                 + longint'(y_old);
            if (t > Y_MAX) begin
               t = Y_MAX;
               r.saturated = 1'b1;
            end
            if (t < Y_MIN) begin
               t = Y_MIN;
               r.saturated = 1'b1;
            end
            r.y_new     = t[31:0];
            r.saturated = r.saturated | row_clip;
         end
         y_due.push_back(r);
         row_acc  = '0;
         row_clip = 1'b0;
      endfunction

      function void note_item(stream_item_type it);
         longint            prod;
         logic [ACC_W:0]    s;
         case (it.op)
            OP_WRITE_X: x_mem[it.index] = it.value;
            OP_NONZERO: begin
               prod = longint'($signed(it.value)) * longint'($signed(x_mem[it.index]));
               s = {row_acc[ACC_W-1], row_acc} + {prod[63], prod};
               if (s[ACC_W] != s[ACC_W-1]) begin
                  row_clip = 1'b1;
                  row_acc  = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
               end else begin
                  row_acc = s[ACC_W-1:0];
               end
               if (it.last) close_row(it.y_old);
            end
            OP_ROW_END: close_row(it.y_old);
            default: ;
         endcase
      endfunction

      function void check_result(logic [DAT_W-1:0] y, logic sat);
         y_result_type e;
         if (y_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: y_new %h saturated %b", y, sat);
            return;
         end
         e = y_due.pop_front();
         if (e.y_new !== y || e.saturated !== sat) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: y_new exp %h got %h, saturated exp %b got %b",
                        e.y_new, y, e.saturated, sat);
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [DAT_W-1:0] csr_wr_data;

   smva_req_if req_chan ();
   smva_rsp_if rsp_chan ();

   csr_sparse_matvec_accumulate_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   spmv_book sb = new();

   bit   x_written [X_DEPTH];
   int   written_cols [$];
   bit   sender_idles = 1'b1;
   bit   rsp_idles    = 1'b1;
   bit   rsp_hold     = 1'b0;
   int   idle_cycles  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // monitor: results first, then the new item
   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_result(rsp_chan.y_new, rsp_chan.saturated);
            moved = 1'b1;
         end
         if (req_chan.valid && req_chan.ready) begin
            sb.note_item({req_chan.op, req_chan.index, req_chan.value,
                          req_chan.last_in_row, req_chan.y_old});
            moved = 1'b1;
         end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         if (rsp_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end else if (rsp_idles && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic stream_item_type pack_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                                 logic [DAT_W-1:0] val, logic last,
                                                 logic [DAT_W-1:0] y_old);
      pack_item = {op, idx, val, last, y_old};
   endfunction

   function automatic logic [DAT_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       pick_word = 32'h7FFF_FFFF;
         1:       pick_word = 32'h8000_0000;
         2:       pick_word = '0;
         3, 4, 5: pick_word = $urandom;
         default: pick_word = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      endcase
   endfunction

   // columns only from x entries already written
   function automatic logic [IDX_W-1:0] pick_col();
      pick_col = written_cols[$urandom_range(0, written_cols.size() - 1)];
   endfunction

   task automatic send(stream_item_type it);
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.op          <= it.op;
      req_chan.index       <= it.index;
      req_chan.value       <= it.value;
      req_chan.last_in_row <= it.last;
      req_chan.y_old       <= it.y_old;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (it.op == OP_WRITE_X && !x_written[it.index]) begin
         x_written[it.index] = 1'b1;
         written_cols.push_back(it.index);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(logic [DAT_W-1:0] v);
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_scale(v);
   endtask

   task automatic run_rows(int n_items, int hold_at);
      int  done_items;
      int  row_len;
      int  r;
      bit  end_marker;
      bit  hold_given;
      done_items = 0;
      hold_given = 1'b0;
      while (done_items < n_items) begin
         if (hold_at >= 0 && done_items >= hold_at && !hold_given) begin
            rsp_hold   = 1'b1;
            hold_given = 1'b1;
         end
         r = $urandom_range(0, 19);
         if (r < 3) begin
            send(pack_item(OP_WRITE_X, 10'($urandom), pick_word(), 1'($urandom), $urandom));
            done_items++;
         end else if (r == 3) begin
            send(pack_item(OP_UNUSED, 10'($urandom), $urandom, 1'($urandom), $urandom));
         end else if (r == 4) begin
            send(pack_item(OP_ROW_END, 10'($urandom), $urandom, 1'($urandom), pick_word()));
            done_items++;
         end else begin
            row_len    = $urandom_range(1, 6);
            end_marker = (r == 5);
            for (int k = 0; k < row_len; k++)
               send(pack_item(OP_NONZERO, pick_col(), pick_word(),
                              !end_marker && k == row_len - 1, pick_word()));
            if (end_marker)
               send(pack_item(OP_ROW_END, 10'($urandom), $urandom, 1'($urandom), pick_word()));
            done_items += row_len + end_marker;
         end
      end
   endtask

   initial begin
      logic [DAT_W-1:0] s;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.op          <= OP_WRITE_X;
      req_chan.index       <= '0;
      req_chan.value       <= '0;
      req_chan.last_in_row <= 1'b0;
      req_chan.y_old       <= '0;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, a = 1.0 from reset
      send(pack_item(OP_WRITE_X, 10'h000, 32'h0001_0000, 1'b0, 32'h0));
      send(pack_item(OP_WRITE_X, 10'h3FF, 32'h7FFF_FFFF, 1'b0, 32'h0));
      send(pack_item(OP_WRITE_X, 10'h2AA, 32'h8000_0000, 1'b0, 32'h0));
      send(pack_item(OP_WRITE_X, 10'h155, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
      send(pack_item(OP_ROW_END, 10'h3FF, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678));
      send(pack_item(OP_NONZERO, 10'h000, 32'h0002_0000, 1'b0, 32'h0));
      send(pack_item(OP_NONZERO, 10'h155, 32'h0000_8000, 1'b1, 32'h0000_0001));
      send(pack_item(OP_NONZERO, 10'h3FF, 32'h7FFF_FFFF, 1'b0, 32'h0));
      send(pack_item(OP_NONZERO, 10'h3FF, 32'h7FFF_FFFF, 1'b0, 32'h0));
      send(pack_item(OP_NONZERO, 10'h3FF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF));
      send(pack_item(OP_NONZERO, 10'h2AA, 32'h7FFF_FFFF, 1'b0, 32'h0));
      send(pack_item(OP_NONZERO, 10'h2AA, 32'h7FFF_FFFF, 1'b0, 32'h0));
      send(pack_item(OP_NONZERO, 10'h2AA, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000));
      send(pack_item(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
      send(pack_item(OP_NONZERO, 10'h000, 32'hFFFF_0000, 1'b0, 32'h0));
      send(pack_item(OP_ROW_END, 10'h000, 32'h0, 1'b0, 32'h7FFF_0000));
      send(pack_item(OP_NONZERO, 10'h2AA, 32'h8000_0000, 1'b1, 32'h8000_0000));

      for (int p = 0; p < 8; p++) begin
         drain();
         case (p)
            0:       s = '0;
            1:       s = 32'h7FFF_FFFF;
            2:       s = 32'h8000_0000;
            3:       s = 32'h0000_8000;
            4:       s = 32'hFFFF_0000;
            5:       s = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            6:       s = $urandom;
            default: s = SCALE_RESET;
         endcase
         if (p == 7) begin
            sender_idles = 1'b0;
            rsp_idles    = 1'b0;
         end
         write_scale(s);
         run_rows(PHASE_ITEMS, (p == 3) ? 60 : -1);
      end
      drain();

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/smva_pkg.sv
hw/rtl/smva_req_if.sv
hw/rtl/smva_rsp_if.sv
hw/rtl/smva_ctrl.sv
hw/rtl/smva_dp.sv
hw/rtl/csr_sparse_matvec_accumulate_unit.sv
tb/tb_top.sv
